### hdl/tti_pkg.sv
package tti_pkg;

   // Item kinds carried in the request beat.
   typedef enum logic [1:0] {
      KIND_LOAD  = 2'd0,
      KIND_ADC2T = 2'd1,
      KIND_T2ADC = 2'd2,
      KIND_NONE  = 2'd3
   } kind_type;

   // Configuration register indexes.
   localparam logic [1:0] CSR_SERIES_RES = 2'd0;
   localparam logic [1:0] CSR_TEMP_STEP  = 2'd1;
   localparam logic [1:0] CSR_USE_FAHR   = 2'd2;

   localparam int CSR_WIDTH = 24;
   localparam int STEP_W    = 10;
   localparam int RES_W     = 32;

   localparam logic [23:0] SERIES_RES_RESET = 24'd10000;
   localparam logic [9:0]  TEMP_STEP_RESET  = 10'd5;

   // Celsius to Fahrenheit: t * 9 / 5 + 32.
   localparam int FAHR_MUL = 9;
   localparam int FAHR_DIV = 5;
   localparam int FAHR_OFS = 32;

   localparam logic [14:0] TEMP_OUT_MAX = 15'h7FFF;
   localparam logic [9:0]  ADC_OUT_MAX  = 10'h3FF;

   typedef struct packed {
      kind_type           kind;
      logic [5:0]         entry_index;
      logic [31:0]        entry_value;
      logic [9:0]         adc_value;
      logic signed [15:0] temperature_in;
   } req_type;

   typedef struct packed {
      logic [14:0] temperature_out;
      logic [9:0]  adc_out;
   } rsp_type;

endpackage

### hdl/thermistor_table_interpolator_unit.sv
// Channel   Direction  Handshake              Payload
// req_      in         req_valid/req_ready    req_data  (tti_pkg::req_type)
// rsp_      out        rsp_valid/rsp_ready    rsp_data  (tti_pkg::rsp_type)
// csr_      in         csr_we (no wait)       csr_index, csr_wdata
//
// A load beat is written to the table as it is accepted. Every divide runs
// on one shared restoring divider that retires one quotient bit per cycle,
// next to one shared 32 x 10 multiplier. An adc-to-temperature beat costs
// at most two divides plus a read and a compare for each table entry
// searched (for Fahrenheit, the divide by five is a reciprocal multiply); a
// temperature-to-adc beat costs at most three divides.
// Reset is synchronous and clears control state and the configuration
// registers; the table holds garbage until loaded. While a result waits on
// rsp_ready the block still takes a new beat, but will not finish it until
// the old result leaves.
module thermistor_table_interpolator_unit
   import tti_pkg::*;
#(
   parameter int TABLE_ENTRIES  = 64,
   parameter int ADC_FULL_SCALE = 1023
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rsp_type              rsp_data,
   input  logic                 csr_we,
   input  logic [1:0]           csr_index,
   input  logic [CSR_WIDTH-1:0] csr_wdata
);

   // Index width for the table, and width of the full-scale constant.
   localparam int IW    = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int FW    = $clog2(ADC_FULL_SCALE + 1);
   // Multiplier operand widths: a 32-bit value times a step or the full scale.
   localparam int YW    = (FW > STEP_W) ? FW : STEP_W;
   localparam int PW    = RES_W + YW;
   // Dividend width: a product plus one carry bit for the blend sum.
   localparam int NUM_W = PW + 1;
   localparam int DW    = RES_W + 1;
   localparam int CW    = $clog2(NUM_W + 1);
   // Temperature width: (entries-1) * step, times 9 for Fahrenheit.
   localparam int TTW   = IW + STEP_W + 4;
   // Divide by five as a reciprocal multiply; exact for any dividend below
   // 2**TTW since the rounding error of the reciprocal stays under 1/5.
   localparam int FSH   = TTW + 3;
   localparam int RCW   = FSH - 2;
   localparam int FPW   = TTW + RCW;

   localparam logic [IW-1:0]    LAST_IDX   = IW'(TABLE_ENTRIES - 1);
   localparam logic [RES_W-1:0] RES_MAX    = '1;
   localparam logic [YW-1:0]    FULL_Y     = YW'(ADC_FULL_SCALE);
   localparam logic [RCW-1:0]   FAHR_RECIP = RCW'((2**FSH + FAHR_DIV - 1) / FAHR_DIV);

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_DIV,
      ST_RSAT,
      ST_SRCH_RD,
      ST_SRCH_CMP,
      ST_INTERP,
      ST_INTERP2,
      ST_IQ,
      ST_TEMP,
      ST_FQ,
      ST_TSAT,
      ST_TSTEP,
      ST_RD_LO,
      ST_GOT_LO,
      ST_RD_HI,
      ST_GOT_HI,
      ST_RVAL,
      ST_RD1,
      ST_GOT1,
      ST_CODE,
      ST_ADCQ,
      ST_OUT
   } state_type;

   // Configuration registers.
   logic [23:0]        series_ff;
   logic [STEP_W-1:0]  step_ff;
   logic               fahr_ff;

   // Sequencer state and working registers.
   state_type          state_ff;
   state_type          ret_ff;
   logic [NUM_W-1:0]   num_ff;
   logic [DW-1:0]      den_ff;
   logic [DW-1:0]      rem_ff;
   logic [CW-1:0]      cnt_ff;
   logic [RES_W-1:0]   r_ff;
   logic [RES_W-1:0]   prev_ff;
   logic [RES_W-1:0]   cur_ff;
   logic [IW-1:0]      idx_ff;
   logic [STEP_W-1:0]  fr_ff;
   logic [TTW-1:0]     t_ff;
   logic [TTW-1:0]     base_ff;
   logic [NUM_W-1:0]   prod_ff;
   rsp_type            pend_ff;
   logic               rsp_valid_ff;
   rsp_type            rsp_data_ff;

   // Resistance table: one write port, one registered read port.
   logic [RES_W-1:0]   table_mem [TABLE_ENTRIES];
   logic [RES_W-1:0]   mem_q_ff;
   logic               mem_we;
   logic [IW-1:0]      mem_waddr;
   logic [31:0]        load_idx;

   logic [STEP_W-1:0]  step_eff;
   logic [RES_W-1:0]   mul_x;
   logic [YW-1:0]      mul_y;
   logic [PW-1:0]      mul_p;
   logic [DW:0]        rem_sh;
   logic               div_ge;
   logic [DW:0]        rem_nx;
   logic [DW-1:0]      code_den;
   logic [FPW-1:0]     fahr_prod;
   logic               accept;

   assign step_eff  = (step_ff == '0) ? STEP_W'(1) : step_ff;
   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign load_idx  = 32'(req_data.entry_index);
   assign mem_waddr = load_idx[IW-1:0];
   assign mem_we    = accept && (req_data.kind == KIND_LOAD)
                      && (load_idx < 32'(TABLE_ENTRIES));

   always_ff @(posedge clock) begin
      if (mem_we) begin
         table_mem[mem_waddr] <= req_data.entry_value;
      end
      mem_q_ff <= table_mem[idx_ff];
   end

   // The one multiplier; its operands follow the sequencer state.
   always_comb begin
      mul_x = '0;
      mul_y = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_data.kind == KIND_ADC2T) begin
               mul_x = RES_W'(series_ff);
               mul_y = YW'(req_data.adc_value);
            end else begin
               mul_x = RES_W'(LAST_IDX);
               mul_y = YW'(step_eff);
            end
         end
         ST_SRCH_CMP: begin
            mul_x = RES_W'(LAST_IDX);
            mul_y = YW'(step_eff);
         end
         ST_INTERP: begin
            mul_x = RES_W'(idx_ff - IW'(1));
            mul_y = YW'(step_eff);
         end
         ST_INTERP2: begin
            mul_x = prev_ff - r_ff;
            mul_y = YW'(step_eff);
         end
         ST_GOT_LO: begin
            mul_x = mem_q_ff;
            mul_y = YW'(step_eff - fr_ff);
         end
         ST_GOT_HI: begin
            mul_x = mem_q_ff;
            mul_y = YW'(fr_ff);
         end
         ST_CODE: begin
            mul_x = r_ff;
            mul_y = FULL_Y;
         end
         ST_TEMP: begin
            mul_x = RES_W'(t_ff);
            mul_y = YW'(FAHR_MUL);
         end
         default: begin
            mul_x = '0;
            mul_y = '0;
         end
      endcase
   end

   assign mul_p = PW'(mul_x) * PW'(mul_y);

   // Constant multiply by the reciprocal of five for the Fahrenheit scale.
   assign fahr_prod = FPW'(t_ff) * FPW'(FAHR_RECIP);

   // One restoring divide step: shift in the next dividend bit, subtract if
   // it fits, and shift the quotient bit into the dividend register.
   assign rem_sh   = {rem_ff, num_ff[NUM_W-1]};
   assign div_ge   = (rem_sh >= {1'b0, den_ff});
   assign rem_nx   = div_ge ? (rem_sh - {1'b0, den_ff}) : rem_sh;
   assign code_den = DW'(r_ff) + DW'(series_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         series_ff    <= SERIES_RES_RESET;
         step_ff      <= TEMP_STEP_RESET;
         fahr_ff      <= 1'b0;
         state_ff     <= ST_IDLE;
         ret_ff       <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
         idx_ff       <= '0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_SERIES_RES: series_ff <= csr_wdata[23:0];
               CSR_TEMP_STEP:  step_ff   <= csr_wdata[STEP_W-1:0];
               CSR_USE_FAHR:   fahr_ff   <= csr_wdata[0];
               default: ;
            endcase
         end

         // The output register fills from the finished result once it is
         // free or being emptied in this cycle.
         if ((state_ff == ST_OUT) && (!rsp_valid_ff || rsp_ready)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  case (req_data.kind)
                     KIND_ADC2T: begin
                        idx_ff  <= '0;
                        pend_ff <= '0;
                        if (32'(req_data.adc_value) >= 32'(ADC_FULL_SCALE)) begin
                           // A full-scale sample means an open divider.
                           r_ff     <= RES_MAX;
                           state_ff <= ST_SRCH_RD;
                        end else begin
                           num_ff   <= NUM_W'(mul_p);
                           den_ff   <= DW'(ADC_FULL_SCALE) - DW'(req_data.adc_value);
                           rem_ff   <= '0;
                           cnt_ff   <= CW'(NUM_W);
                           ret_ff   <= ST_RSAT;
                           state_ff <= ST_DIV;
                        end
                     end
                     KIND_T2ADC: begin
                        pend_ff <= '0;
                        if (req_data.temperature_in[15]) begin
                           idx_ff   <= '0;
                           state_ff <= ST_RD1;
                        end else if (PW'(req_data.temperature_in[14:0]) >= mul_p) begin
                           idx_ff   <= LAST_IDX;
                           state_ff <= ST_RD1;
                        end else begin
                           num_ff   <= NUM_W'(req_data.temperature_in[14:0]);
                           den_ff   <= DW'(step_eff);
                           rem_ff   <= '0;
                           cnt_ff   <= CW'(NUM_W);
                           ret_ff   <= ST_TSTEP;
                           state_ff <= ST_DIV;
                        end
                     end
                     default: ;
                  endcase
               end
            end

            ST_DIV: begin
               rem_ff <= rem_nx[DW-1:0];
               num_ff <= {num_ff[NUM_W-2:0], div_ge};
               cnt_ff <= cnt_ff - CW'(1);
               if (cnt_ff == CW'(1)) begin
                  state_ff <= ret_ff;
               end
            end

            ST_RSAT: begin
               r_ff     <= (|num_ff[NUM_W-1:RES_W]) ? RES_MAX : num_ff[RES_W-1:0];
               state_ff <= ST_SRCH_RD;
            end

            ST_SRCH_RD: begin
               state_ff <= ST_SRCH_CMP;
            end

            ST_SRCH_CMP: begin
               if (r_ff >= mem_q_ff) begin
                  if (idx_ff == '0) begin
                     t_ff     <= '0;
                     state_ff <= ST_TEMP;
                  end else begin
                     cur_ff   <= mem_q_ff;
                     state_ff <= ST_INTERP;
                  end
               end else begin
                  prev_ff <= mem_q_ff;
                  if (idx_ff == LAST_IDX) begin
                     // Resistance below the last entry clamps to the top.
                     t_ff     <= TTW'(mul_p);
                     state_ff <= ST_TEMP;
                  end else begin
                     idx_ff   <= idx_ff + IW'(1);
                     state_ff <= ST_SRCH_RD;
                  end
               end
            end

            ST_INTERP: begin
               base_ff  <= TTW'(mul_p);
               state_ff <= ST_INTERP2;
            end

            // The blend reduces to base + step * (prev - r) / (prev - cur).
            ST_INTERP2: begin
               num_ff   <= NUM_W'(mul_p);
               den_ff   <= DW'(prev_ff - cur_ff);
               rem_ff   <= '0;
               cnt_ff   <= CW'(NUM_W);
               ret_ff   <= ST_IQ;
               state_ff <= ST_DIV;
            end

            ST_IQ: begin
               t_ff     <= base_ff + TTW'(num_ff);
               state_ff <= ST_TEMP;
            end

            ST_TEMP: begin
               if (fahr_ff) begin
                  t_ff     <= TTW'(mul_p);
                  state_ff <= ST_FQ;
               end else begin
                  state_ff <= ST_TSAT;
               end
            end

            ST_FQ: begin
               t_ff     <= TTW'(fahr_prod >> FSH) + TTW'(FAHR_OFS);
               state_ff <= ST_TSAT;
            end

            ST_TSAT: begin
               pend_ff.temperature_out <= (t_ff > TTW'(TEMP_OUT_MAX))
                                          ? TEMP_OUT_MAX : t_ff[14:0];
               state_ff <= ST_OUT;
            end

            // Quotient is the lower entry, remainder the distance past it.
            ST_TSTEP: begin
               idx_ff   <= num_ff[IW-1:0];
               fr_ff    <= rem_ff[STEP_W-1:0];
               state_ff <= ST_RD_LO;
            end

            ST_RD_LO: begin
               state_ff <= ST_GOT_LO;
            end

            ST_GOT_LO: begin
               prod_ff  <= NUM_W'(mul_p);
               idx_ff   <= idx_ff + IW'(1);
               state_ff <= ST_RD_HI;
            end

            ST_RD_HI: begin
               state_ff <= ST_GOT_HI;
            end

            ST_GOT_HI: begin
               num_ff   <= prod_ff + NUM_W'(mul_p);
               den_ff   <= DW'(step_eff);
               rem_ff   <= '0;
               cnt_ff   <= CW'(NUM_W);
               ret_ff   <= ST_RVAL;
               state_ff <= ST_DIV;
            end

            ST_RVAL: begin
               r_ff     <= num_ff[RES_W-1:0];
               state_ff <= ST_CODE;
            end

            ST_RD1: begin
               state_ff <= ST_GOT1;
            end

            ST_GOT1: begin
               r_ff     <= mem_q_ff;
               state_ff <= ST_CODE;
            end

            ST_CODE: begin
               if (code_den == '0) begin
                  pend_ff.adc_out <= '0;
                  state_ff        <= ST_OUT;
               end else begin
                  num_ff   <= NUM_W'(mul_p);
                  den_ff   <= code_den;
                  rem_ff   <= '0;
                  cnt_ff   <= CW'(NUM_W);
                  ret_ff   <= ST_ADCQ;
                  state_ff <= ST_DIV;
               end
            end

            ST_ADCQ: begin
               pend_ff.adc_out <= (|num_ff[NUM_W-1:10]) ? ADC_OUT_MAX : num_ff[9:0];
               state_ff        <= ST_OUT;
            end

            ST_OUT: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_data_ff  <= pend_ff;
                  state_ff     <= ST_IDLE;
               end
            end

            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

### tb/tb.sv
module tb;
   import tti_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int ENTRIES = 64;
   localparam int FULL_SCALE = 1023;
   localparam int QUIET_CYCLES = 600;
   localparam int STALL_LIMIT = 20000;
   localparam int PHASE_COUNT = 6;
   localparam int ITEMS_PER_PHASE = 95;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_ready;
   req_type req_data;
   logic rsp_valid;
   logic rsp_ready;
   rsp_type rsp_data;
   logic csr_we;
   logic [1:0] csr_index;
   logic [CSR_WIDTH-1:0] csr_wdata;

   thermistor_table_interpolator_unit dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   // Our own copy of the block's state and registers, updated as beats are
   // accepted and registers are written.
   logic [31:0] ohm_table [ENTRIES];
   logic [23:0] divider_ohms;
   logic [9:0] step_reg;
   logic fahrenheit_on;

   // Results still owed by the block, oldest first.
   rsp_type owed_results[$];

   int idle_mode;
   int mismatches;
   int loads_sent;
   int temp_queries;
   int code_queries;
   int results_seen;
   int stall_cycles;
   bit timed_out;

   typedef struct {
      kind_type kind;
      logic [5:0] idx;
      logic [31:0] value;
      logic [9:0] adc;
      logic signed [15:0] temp;
      bit typed;
      logic [14:0] temp_exp;
      logic [9:0] code_exp;
   } directed_row_type;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Temperature for a converter sample: divider resistance, table search
   // for the first entry not above it, then linear interpolation.
   function automatic logic [14:0] temperature_for_sample(logic [9:0] adc);
      longint unsigned step;
      longint unsigned r;
      longint unsigned t;
      longint unsigned prev;
      longint unsigned cur;
      int i;
      step = (step_reg == 0) ? 1 : step_reg;
      if (adc >= FULL_SCALE) begin
         r = 64'hFFFF_FFFF;
      end else begin
         r = (longint'(divider_ohms) * adc) / (FULL_SCALE - adc);
         if (r > 64'hFFFF_FFFF) r = 64'hFFFF_FFFF;
      end
      i = 0;
      while (i < ENTRIES && r < ohm_table[i]) i++;
      if (i == 0) begin
         t = 0;
      end else if (i >= ENTRIES) begin
         t = (ENTRIES - 1) * step;
      end else begin
         prev = ohm_table[i-1];
         cur = ohm_table[i];
         t = ((i - 1) * step * (r - cur) + i * step * (prev - r)) / (prev - cur);
      end
      if (fahrenheit_on) t = (t * 9) / 5 + 32;
      if (t > 32767) t = 32767;
      return t[14:0];
   endfunction

   // Converter code for a temperature: interpolated resistance, clamped to
   // the table ends, then the divider ratio scaled to full scale.
   function automatic logic [9:0] code_for_temperature(logic signed [15:0] temp);
      longint unsigned step;
      longint unsigned r;
      longint unsigned t;
      longint unsigned lo;
      longint unsigned x0;
      longint unsigned den;
      longint unsigned code;
      step = (step_reg == 0) ? 1 : step_reg;
      if (temp < 0) begin
         r = ohm_table[0];
      end else if (longint'(temp) >= (ENTRIES - 1) * step) begin
         r = ohm_table[ENTRIES-1];
      end else begin
         t = temp;
         lo = t / step;
         x0 = lo * step;
         r = (longint'(ohm_table[lo]) * (x0 + step - t)
              + longint'(ohm_table[lo+1]) * (t - x0)) / step;
      end
      den = r + divider_ohms;
      if (den == 0) return '0;
      code = (r * FULL_SCALE) / den;
      if (code > 1023) code = 1023;
      return code[9:0];
   endfunction

   // Drives one request beat, holding it until accepted. The caller is at a
   // falling edge; valid is left high so that a back-to-back beat follows.
   task automatic send_beat(req_type beat, bit typed, rsp_type typed_rsp);
      int gap;
      rsp_type owed;
      gap = 0;
      if (idle_mode == 0 && $urandom_range(99) < 6) gap = $urandom_range(3, 1);
      if (idle_mode == 1 && $urandom_range(99) < 63) gap = $urandom_range(4, 1);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= beat;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      case (beat.kind)
         KIND_LOAD: begin
            ohm_table[beat.entry_index] = beat.entry_value;
            loads_sent++;
         end
         KIND_ADC2T: begin
            owed.temperature_out = temperature_for_sample(beat.adc_value);
            owed.adc_out = '0;
            owed_results.push_back(typed ? typed_rsp : owed);
            temp_queries++;
         end
         KIND_T2ADC: begin
            owed.temperature_out = '0;
            owed.adc_out = code_for_temperature(beat.temperature_in);
            owed_results.push_back(typed ? typed_rsp : owed);
            code_queries++;
         end
         default: ;
      endcase
      @(negedge clock);
   endtask

   // Drops valid, waits until nothing is owed, then lets a load still in
   // flight settle.
   task automatic drain();
      req_valid <= 1'b0;
      while (owed_results.size() != 0) @(negedge clock);
      repeat (QUIET_CYCLES) @(negedge clock);
   endtask

   // Writes the three registers in consecutive cycles. Called only when idle.
   task automatic write_settings(logic [23:0] ohms, logic [9:0] step, logic fahr);
      csr_we <= 1'b1;
      csr_index <= CSR_SERIES_RES;
      csr_wdata <= ohms;
      @(negedge clock);
      csr_index <= CSR_TEMP_STEP;
      csr_wdata <= CSR_WIDTH'(step);
      @(negedge clock);
      csr_index <= CSR_USE_FAHR;
      csr_wdata <= CSR_WIDTH'(fahr);
      @(negedge clock);
      csr_we <= 1'b0;
      divider_ohms = ohms;
      step_reg = step;
      fahrenheit_on = fahr;
   endtask

   // One random beat. Loads mostly keep the table falling by landing between
   // the neighbors; queries lean toward the sample and temperature edges.
   task automatic random_beat();
      req_type beat;
      logic [31:0] hi;
      logic [31:0] lo;
      int pick;
      int span;
      rsp_type none;
      none = '0;
      beat.kind = kind_type'($urandom_range(3));
      beat.entry_index = 6'($urandom);
      beat.entry_value = $urandom;
      beat.adc_value = 10'($urandom);
      beat.temperature_in = 16'($urandom);
      pick = $urandom_range(99);
      if (pick < 20) begin
         beat.kind = KIND_LOAD;
         hi = (beat.entry_index == 0) ? 32'hFFFF_FFFF : ohm_table[beat.entry_index - 1];
         lo = (beat.entry_index == ENTRIES - 1) ? 32'h0 : ohm_table[beat.entry_index + 1];
         if ($urandom_range(9) < 8 && hi >= lo)
            beat.entry_value = $urandom_range(hi, lo);
      end else if (pick < 58) begin
         beat.kind = KIND_ADC2T;
         case ($urandom_range(5))
            0: beat.adc_value = 10'($urandom_range(1023, 1015));
            1: beat.adc_value = 10'($urandom_range(8, 0));
            default: beat.adc_value = 10'($urandom_range(1023));
         endcase
      end else if (pick < 95) begin
         beat.kind = KIND_T2ADC;
         span = (ENTRIES - 1) * ((step_reg == 0) ? 1 : step_reg);
         if ($urandom_range(9) < 7)
            beat.temperature_in = 16'($urandom_range(span > 32767 ? 32767 : span + 2));
      end else begin
         beat.kind = KIND_NONE;
      end
      send_beat(beat, 1'b0, none);
   endtask

   // Result checker: every accepted result beat is compared with the oldest
   // owed result.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen++;
         if (owed_results.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected result beat temperature_out=%0d adc_out=%0d",
                     $time, rsp_data.temperature_out, rsp_data.adc_out);
         end else begin
            if (rsp_data.temperature_out !== owed_results[0].temperature_out) begin
               mismatches++;
               $display("%0t: temperature_out expected %0d actual %0d", $time,
                        owed_results[0].temperature_out, rsp_data.temperature_out);
            end
            if (rsp_data.adc_out !== owed_results[0].adc_out) begin
               mismatches++;
               $display("%0t: adc_out expected %0d actual %0d", $time,
                        owed_results[0].adc_out, rsp_data.adc_out);
            end
            void'(owed_results.pop_front());
         end
      end
   end

   // The receiver stalls at random according to the current idle mode.
   always @(negedge clock) begin
      case (idle_mode)
         0: rsp_ready <= ($urandom_range(99) >= 63);
         1: rsp_ready <= ($urandom_range(99) >= 6);
         default: rsp_ready <= 1'b1;
      endcase
   end

   // Watchdog: counts cycles with no beat accepted on either channel.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
         $display("end of test: mismatches");
         $finish;
      end
   end

   initial begin
      directed_row_type rows [11];
      req_type beat;
      rsp_type typed_rsp;
      int phase;
      int n;

      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_ready = 1'b0;
      csr_we = 1'b0;
      csr_index = CSR_SERIES_RES;
      csr_wdata = '0;
      idle_mode = 0;
      mismatches = 0;
      loads_sent = 0;
      temp_queries = 0;
      code_queries = 0;
      results_seen = 0;
      stall_cycles = 0;
      divider_ohms = SERIES_RES_RESET;
      step_reg = TEMP_STEP_RESET;
      fahrenheit_on = 1'b0;
      foreach (ohm_table[i]) ohm_table[i] = '0;

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Fill the whole table first, falling from 200000 ohms by 3000 per
      // entry, so no query ever reads an entry that was never written.
      typed_rsp = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         beat = '0;
         beat.kind = KIND_LOAD;
         beat.entry_index = 6'(i);
         beat.entry_value = 32'(200000 - i * 3000);
         send_beat(beat, 1'b0, typed_rsp);
      end

      // Directed rows at reset settings (10000 ohms, step 5, Celsius).
      // Full-scale sample saturates the resistance: temperature 0.
      rows[0] = '{KIND_ADC2T, 6'd0, 32'd0, 10'd1023, 16'sd0, 1'b1, 15'd0, 10'd0};
      // Zero sample is below the last entry: clamps to 63 * 5.
      rows[1] = '{KIND_ADC2T, 6'd0, 32'd0, 10'd0, 16'sd0, 1'b1, 15'd315, 10'd0};
      // Temperature below the table uses the first entry (200000 ohms).
      rows[2] = '{KIND_T2ADC, 6'd0, 32'd0, 10'd0, -16'sd32768, 1'b1, 15'd0, 10'd974};
      // Temperature above the table uses the last entry (11000 ohms).
      rows[3] = '{KIND_T2ADC, 6'd0, 32'd0, 10'd0, 16'sd32767, 1'b1, 15'd0, 10'd535};
      // The unused kind is dropped with no result.
      rows[4] = '{KIND_NONE, 6'h3F, 32'hFFFF_FFFF, 10'h3FF, -16'sd1, 1'b0, 15'd0, 10'd0};
      rows[5] = '{KIND_ADC2T, 6'd0, 32'd0, 10'd512, 16'sd0, 1'b0, 15'd0, 10'd0};
      rows[6] = '{KIND_T2ADC, 6'd0, 32'd0, 10'd0, 16'sd7, 1'b0, 15'd0, 10'd0};
      // Extreme entry values at both table ends.
      rows[7] = '{KIND_LOAD, 6'd0, 32'hFFFF_FFFF, 10'd0, 16'sd0, 1'b0, 15'd0, 10'd0};
      rows[8] = '{KIND_ADC2T, 6'd0, 32'd0, 10'd1023, 16'sd0, 1'b1, 15'd0, 10'd0};
      rows[9] = '{KIND_LOAD, 6'd63, 32'd0, 10'd0, 16'sd0, 1'b0, 15'd0, 10'd0};
      // A zero last entry gives code 0 above the table.
      rows[10] = '{KIND_T2ADC, 6'd0, 32'd0, 10'd0, 16'sd32767, 1'b1, 15'd0, 10'd0};

      foreach (rows[i]) begin
         beat.kind = rows[i].kind;
         beat.entry_index = rows[i].idx;
         beat.entry_value = rows[i].value;
         beat.adc_value = rows[i].adc;
         beat.temperature_in = rows[i].temp;
         typed_rsp.temperature_out = rows[i].temp_exp;
         typed_rsp.adc_out = rows[i].code_exp;
         send_beat(beat, rows[i].typed, typed_rsp);
      end

      // Random phases, each under its own settings. Idle modes: sender light
      // and receiver heavy, then the reverse, then no idling at all.
      for (phase = 0; phase < PHASE_COUNT; phase++) begin
         drain();
         idle_mode = phase / 2;
         case (phase)
            1: write_settings(24'd1, 10'd1, 1'b0);
            2: write_settings(24'hFF_FFFF, 10'd1000, 1'b1);
            3: write_settings(24'd0, 10'd0, 1'b1);
            4: write_settings(24'($urandom), 10'($urandom_range(1000, 1)),
                              1'($urandom_range(1)));
            5: write_settings(24'd10000, 10'd5, 1'b0);
            default: ;
         endcase
         for (n = 0; n < ITEMS_PER_PHASE; n++) random_beat();
      end

      req_valid <= 1'b0;
      drain();

      $display("Sent %0d table loads, %0d sample-to-temperature and %0d temperature-to-code",
               loads_sent, temp_queries, code_queries);
      $display("queries over %0d register settings; %0d result beats checked.",
               PHASE_COUNT, results_seen);
      if (mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
